@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the stereo gain and pan block.
// Depends on signals named clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPSGP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPSGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/spsgp_pkg.sv @@
// Types, constants and step functions for the stereo gain and pan pipeline.
// No dependencies; used by the square root and divider pipes and the top level.
package spsgp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_LISTENER_X = 3'd0;
    localparam logic [2:0] REG_LISTENER_Y = 3'd1;
    localparam logic [2:0] REG_LISTENER_Z = 3'd2;
    localparam logic [2:0] REG_TANGENT_X  = 3'd3;
    localparam logic [2:0] REG_TANGENT_Y  = 3'd4;
    localparam logic [2:0] REG_TANGENT_Z  = 3'd5;
    localparam logic [2:0] REG_TIME_SCALE = 3'd6;
    localparam logic [2:0] REG_ATT_DIST   = 3'd7;

    localparam int CULL_DISTANCE = 38400;
    localparam logic [49:0] CULL_SQ = 50'(CULL_DISTANCE) * 50'(CULL_DISTANCE);

    // Pipeline depths of the iterative units.
    localparam int SQ_STEPS  = 25;
    localparam int DIV_STEPS = 17;
    localparam int ATT_STEPS = 12;

    typedef enum logic [1:0] {
        KIND_SPATIAL,
        KIND_FLAT,
        KIND_MUTE,
        KIND_CULL
    } kind_t;

    // What every item carries alongside the arithmetic.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] gain;
        logic [15:0] pitch_o;
    } item_t;

    // One stage of the square root pipe.
    typedef struct packed {
        item_t              item;
        logic signed [42:0] dot;
        logic [49:0]        rad;
        logic [26:0]        rem;
        logic [24:0]        root;
    } sq_t;

    // One stage of the divider pipe: pan quotient and attenuation quotient.
    typedef struct packed {
        item_t       item;
        logic [24:0] divisor;
        logic        dist_zero;
        logic        dot_neg;
        logic [16:0] dot_low;
        logic [24:0] prem;
        logic [16:0] pq;
        logic        atten_zero;
        logic [22:0] arem;
        logic [11:0] aq;
    } div_t;

    // One radix-4 digit of the restoring square root.
    function automatic sq_t sq_step(sq_t s);
        sq_t         r;
        logic [26:0] rem2;
        logic [26:0] trial;
        r     = s;
        rem2  = {s.rem[24:0], s.rad[49:48]};
        trial = {s.root, 2'b01};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {s.root[23:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {s.root[23:0], 1'b0};
        end
        r.rad = {s.rad[47:0], 2'b00};
        return r;
    endfunction

    // One quotient bit of each restoring division.
    function automatic div_t div_step(div_t s, logic do_att, logic [22:0] att);
        div_t        r;
        logic [25:0] p2;
        logic [23:0] a2;
        r  = s;
        p2 = {s.prem, s.dot_low[16]};
        if (p2 >= {1'b0, s.divisor})
        begin
            r.prem = 25'(p2 - {1'b0, s.divisor});
            r.pq   = {s.pq[15:0], 1'b1};
        end
        else
        begin
            r.prem = p2[24:0];
            r.pq   = {s.pq[15:0], 1'b0};
        end
        r.dot_low = {s.dot_low[15:0], 1'b0};
        a2 = {s.arem, 1'b0};
        if (do_att)
        begin
            if (a2 >= {1'b0, att})
            begin
                r.arem = 23'(a2 - {1'b0, att});
                r.aq   = {s.aq[10:0], 1'b1};
            end
            else
            begin
                r.arem = a2[22:0];
                r.aq   = {s.aq[10:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/spsgp_src_if.sv @@
// Source item channel: one sound source per transaction.
// No dependencies.
interface spsgp_src_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] src_x;
    logic signed [23:0] src_y;
    logic signed [23:0] src_z;
    logic [15:0]        gain;
    logic [15:0]        pitch;
    logic               is_spatial;
    logic               is_looping;
    logic               emits;
    logic               visible;

    modport source (output valid, src_x, src_y, src_z, gain, pitch, is_spatial, is_looping,
                    emits, visible, input ready);
    modport sink (input valid, src_x, src_y, src_z, gain, pitch, is_spatial, is_looping,
                  emits, visible, output ready);
endinterface

@@ hw/rtl/spsgp_res_if.sv @@
// Result channel: channel gains, pitch and stop flag per transaction.
// No dependencies.
interface spsgp_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_gain;
    logic [15:0] right_gain;
    logic [15:0] pitch_out;
    logic        stop_source;

    modport source (output valid, left_gain, right_gain, pitch_out, stop_source, input ready);
    modport sink (input valid, left_gain, right_gain, pitch_out, stop_source, output ready);
endinterface

@@ hw/rtl/spsgp_cfg_if.sv @@
// Configuration write channel: register index and write data per transaction.
// No dependencies.
interface spsgp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/spsgp_sqrt.sv @@
// Pipelined integer square root, one radix-4 digit per stage, with sideband.
// Depends on spsgp_pkg.
module spsgp_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  spsgp_pkg::sq_t  in_data,
    output logic            out_valid,
    output spsgp_pkg::sq_t  out_data
);
    import spsgp_pkg::*;

    sq_t                 stage_reg [SQ_STEPS];
    sq_t                 stage_next [SQ_STEPS];
    logic [SQ_STEPS-1:0] valid_reg;

    // Each stage resolves one root bit from the previous stage.
    always_comb
    begin
        stage_next[0] = sq_step(in_data);
        for (int k = 1; k < SQ_STEPS; k++)
        begin
            stage_next[k] = sq_step(stage_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[SQ_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[SQ_STEPS-1];
    assign out_data  = stage_reg[SQ_STEPS-1];

endmodule

@@ hw/rtl/spsgp_div.sv @@
// Pipelined restoring dividers for the pan quotient and the distance attenuation.
// Depends on spsgp_pkg.
module spsgp_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [22:0]     att,
    input  logic            in_valid,
    input  spsgp_pkg::div_t in_data,
    output logic            out_valid,
    output spsgp_pkg::div_t out_data
);
    import spsgp_pkg::*;

    div_t                 stage_reg [DIV_STEPS];
    div_t                 stage_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] valid_reg;

    // One quotient bit per stage; the attenuation needs only the first stages.
    always_comb
    begin
        stage_next[0] = div_step(in_data, 1'b1, att);
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            stage_next[k] = div_step(stage_reg[k-1], (k < ATT_STEPS), att);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_data  = stage_reg[DIV_STEPS-1];

endmodule

@@ hw/rtl/spatial_stereo_gain_pan.sv @@
// Stereo gain, pan and pitch for one sound source per transaction. The block takes a new
// source in every cycle unless the result side holds off. Its registered steps, in order,
// are the offsets, the squares and the sums, the square root (one root bit per stage), the
// divider set-up, the pan and attenuation division (one quotient bit per stage), the pan
// factors, the channel products, the clamp and gain and the output register. When the
// result side holds off, the whole pipeline holds with it and no transaction is lost.
`include "assert_macros.svh"

module spatial_stereo_gain_pan (
    input  logic clk,
    input  logic rst_n,
    spsgp_src_if.sink   src,
    spsgp_res_if.source res,
    spsgp_cfg_if.sink   cfg
);
    import spsgp_pkg::*;

    // Configuration registers.
    logic signed [23:0] lx_reg, ly_reg, lz_reg;
    logic signed [15:0] tx_reg, ty_reg, tz_reg;
    logic [15:0]        ts_reg;
    logic [22:0]        att_reg;

    logic en;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg  <= '0;
            ly_reg  <= '0;
            lz_reg  <= '0;
            tx_reg  <= 16'sd16384;
            ty_reg  <= '0;
            tz_reg  <= '0;
            ts_reg  <= 16'd4096;
            att_reg <= 23'd32000;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LISTENER_X: lx_reg  <= cfg.data;
                REG_LISTENER_Y: ly_reg  <= cfg.data;
                REG_LISTENER_Z: lz_reg  <= cfg.data;
                REG_TANGENT_X:  tx_reg  <= cfg.data[15:0];
                REG_TANGENT_Y:  ty_reg  <= cfg.data[15:0];
                REG_TANGENT_Z:  tz_reg  <= cfg.data[15:0];
                REG_TIME_SCALE: ts_reg  <= cfg.data[15:0];
                REG_ATT_DIST:   att_reg <= cfg.data[22:0];
                default:        ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being emptied.
    logic out_valid_reg;
    assign en        = !out_valid_reg || res.ready;
    assign src.ready = en;

    // Stage 1: offsets from the listener.
    logic               s1_valid_reg;
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic signed [24:0] dx_next, dy_next, dz_next;
    logic [15:0]        s1_gain_reg, s1_pitch_reg;
    logic               s1_spatial_reg, s1_looping_reg, s1_mute_reg;

    always_comb
    begin
        dx_next = {src.src_x[23], src.src_x} - {lx_reg[23], lx_reg};
        dy_next = {src.src_y[23], src.src_y} - {ly_reg[23], ly_reg};
        dz_next = {src.src_z[23], src.src_z} - {lz_reg[23], lz_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            dz_reg         <= dz_next;
            s1_gain_reg    <= src.gain;
            s1_pitch_reg   <= src.pitch;
            s1_spatial_reg <= src.is_spatial;
            s1_looping_reg <= src.is_looping;
            s1_mute_reg    <= !src.emits || !src.visible || (src.gain == '0);
        end
    end

    // Stage 2: squares, tangent products and the scaled pitch.
    logic               s2_valid_reg;
    logic [48:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [40:0] px_reg, py_reg, pz_reg;
    logic [31:0]        pp_reg;
    logic [15:0]        s2_gain_reg, s2_pitch_reg;
    logic               s2_spatial_reg, s2_looping_reg, s2_mute_reg;
    logic [49:0]        sqx_next, sqy_next, sqz_next;

    always_comb
    begin
        sqx_next = 50'(dx_reg * dx_reg);
        sqy_next = 50'(dy_reg * dy_reg);
        sqz_next = 50'(dz_reg * dz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg        <= sqx_next[48:0];
            sqy_reg        <= sqy_next[48:0];
            sqz_reg        <= sqz_next[48:0];
            px_reg         <= 41'(dx_reg * tx_reg);
            py_reg         <= 41'(dy_reg * ty_reg);
            pz_reg         <= 41'(dz_reg * tz_reg);
            pp_reg         <= s1_pitch_reg * ts_reg;
            s2_gain_reg    <= s1_gain_reg;
            s2_pitch_reg   <= s1_pitch_reg;
            s2_spatial_reg <= s1_spatial_reg;
            s2_looping_reg <= s1_looping_reg;
            s2_mute_reg    <= s1_mute_reg;
        end
    end

    // Stage 3: distance squared, dot product and the kind of result.
    logic        s3_valid_reg;
    sq_t         sq_in_reg, sq_in_next;
    logic [49:0] dsq_next;

    always_comb
    begin
        dsq_next = {1'b0, sqx_reg} + {1'b0, sqy_reg} + {1'b0, sqz_reg};
        sq_in_next      = '0;
        sq_in_next.rad  = dsq_next;
        sq_in_next.dot  = 43'(px_reg) + 43'(py_reg) + 43'(pz_reg);
        sq_in_next.item.gain = s2_gain_reg;
        if (s2_looping_reg && s2_spatial_reg && (dsq_next > CULL_SQ))
        begin
            sq_in_next.item.kind = KIND_CULL;
        end
        else if (s2_mute_reg)
        begin
            sq_in_next.item.kind = KIND_MUTE;
        end
        else if (!s2_spatial_reg)
        begin
            sq_in_next.item.kind = KIND_FLAT;
        end
        else
        begin
            sq_in_next.item.kind = KIND_SPATIAL;
        end
        if (!s2_spatial_reg)
        begin
            sq_in_next.item.pitch_o = s2_pitch_reg;
        end
        else if (pp_reg[31:28] != '0)
        begin
            sq_in_next.item.pitch_o = 16'hFFFF;
        end
        else
        begin
            sq_in_next.item.pitch_o = pp_reg[27:12];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_in_reg <= sq_in_next;
        end
    end

    // Square root of the distance squared.
    logic sq_out_valid;
    sq_t  sq_out;

    spsgp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_data   (sq_in_reg),
        .out_valid (sq_out_valid),
        .out_data  (sq_out)
    );

    // Stage 4: divider set-up: dot magnitude and the distance left before silence.
    logic        s4_valid_reg;
    div_t        div_in_reg, div_in_next;
    logic [42:0] mag;

    always_comb
    begin
        mag = sq_out.dot[42] ? 43'(-sq_out.dot) : 43'(sq_out.dot);
        div_in_next           = '0;
        div_in_next.item      = sq_out.item;
        div_in_next.divisor   = sq_out.root;
        div_in_next.dist_zero = (sq_out.root == '0);
        div_in_next.dot_neg   = sq_out.dot[42];
        div_in_next.prem      = mag[41:17];
        div_in_next.dot_low   = mag[16:0];
        if (sq_out.root < {2'b00, att_reg})
        begin
            div_in_next.arem       = att_reg - sq_out.root[22:0];
            div_in_next.atten_zero = 1'b0;
        end
        else
        begin
            div_in_next.atten_zero = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_in_reg <= div_in_next;
        end
    end

    logic div_out_valid;
    div_t div_out;

    spsgp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .att       (att_reg),
        .in_valid  (s4_valid_reg),
        .in_data   (div_in_reg),
        .out_valid (div_out_valid),
        .out_data  (div_out)
    );

    // Stage 5: signed pan and the two pan factors.
    logic               s5_valid_reg;
    item_t              s5_item_reg;
    logic [12:0]        s5_atten_reg;
    logic signed [18:0] fl_reg, fr_reg;
    logic signed [17:0] pan_next;

    always_comb
    begin
        if (div_out.dist_zero)
        begin
            pan_next = {{2{tz_reg[15]}}, tz_reg};
        end
        else if (div_out.dot_neg)
        begin
            pan_next = -$signed({1'b0, div_out.pq});
        end
        else
        begin
            pan_next = $signed({1'b0, div_out.pq});
        end
    end

    // A source at the listener is at full attenuation gain, one more than the quotient holds.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_item_reg  <= div_out.item;
            s5_atten_reg <= div_out.atten_zero ? 13'd0 :
                            (div_out.dist_zero ? 13'd4096 : {1'b0, div_out.aq});
            fl_reg       <= 19'sd16384 - {pan_next[17], pan_next};
            fr_reg       <= 19'sd16384 + {pan_next[17], pan_next};
        end
    end

    // Stage 6: attenuation times pan factor.
    logic               s6_valid_reg;
    item_t              s6_item_reg;
    logic signed [31:0] pl_reg, pr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_item_reg <= s5_item_reg;
            pl_reg      <= 32'($signed({1'b0, s5_atten_reg}) * fl_reg);
            pr_reg      <= 32'($signed({1'b0, s5_atten_reg}) * fr_reg);
        end
    end

    // Stage 7: clamp the channel attenuations and apply the source gain.
    logic        s7_valid_reg;
    item_t       s7_item_reg;
    logic [28:0] gl_reg, gr_reg;
    logic [12:0] la, ra;

    always_comb
    begin
        if (pl_reg[31])
        begin
            la = '0;
        end
        else if (pl_reg[30:15] > 16'd4096)
        begin
            la = 13'd4096;
        end
        else
        begin
            la = pl_reg[27:15];
        end
        if (pr_reg[31])
        begin
            ra = '0;
        end
        else if (pr_reg[30:15] > 16'd4096)
        begin
            ra = 13'd4096;
        end
        else
        begin
            ra = pr_reg[27:15];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_item_reg <= s6_item_reg;
            gl_reg      <= s6_item_reg.gain * la;
            gr_reg      <= s6_item_reg.gain * ra;
        end
    end

    // Output register: choose the result by kind.
    logic [15:0] left_reg, right_reg, pitch_reg;
    logic        stop_reg;
    logic [15:0] left_next, right_next, pitch_next;
    logic        stop_next;

    always_comb
    begin
        left_next  = '0;
        right_next = '0;
        pitch_next = '0;
        stop_next  = 1'b0;
        case (s7_item_reg.kind)
            KIND_CULL:
            begin
                stop_next = 1'b1;
            end
            KIND_MUTE:
            begin
                stop_next = 1'b0;
            end
            KIND_FLAT:
            begin
                left_next  = s7_item_reg.gain;
                right_next = s7_item_reg.gain;
                pitch_next = s7_item_reg.pitch_o;
            end
            KIND_SPATIAL:
            begin
                left_next  = gl_reg[27:12];
                right_next = gr_reg[27:12];
                pitch_next = s7_item_reg.pitch_o;
            end
            default:
            begin
                stop_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            pitch_reg <= pitch_next;
            stop_reg  <= stop_next;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= src.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= sq_out_valid;
            s5_valid_reg  <= div_out_valid;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= s7_valid_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.left_gain   = left_reg;
    assign res.right_gain  = right_reg;
    assign res.pitch_out   = pitch_reg;
    assign res.stop_source = stop_reg;

    // A stopped source carries no gain and no pitch.
    `SPSGP_ASSERT_IMPLY(a_stop_silent, res.valid && res.stop_source,
        (res.left_gain == '0) && (res.right_gain == '0) && (res.pitch_out == '0),
        "stopped source with non-zero output")

    // An accepted source always enters the first stage.
    `SPSGP_ASSERT_NEXT(a_accept_enters, src.valid && src.ready, s1_valid_reg,
        "accepted source missing from the first stage")

    // A stalled final stage is still there once the stall ends.
    `SPSGP_ASSERT_NEXT(a_stall_keeps, s7_valid_reg && !en, s7_valid_reg,
        "final stage lost during a stall")

endmodule
